@@ hdl/acwu_pkg.sv @@
// acwu_pkg: shared constants, codes and command/status types for the
// accumulator calculator with undo. no dependencies.
package acwu_pkg;

    localparam int DATA_W        = 48;
    localparam int FRAC_W        = 16;
    localparam int FUNC_W        = 3;
    localparam int HISTORY_DEPTH = 64;
    localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int HALF_W        = DATA_W / 2;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int QUO_W         = DATA_W + FRAC_W;
    localparam int SATIN_W       = PROD_W - FRAC_W;
    localparam int STEP_W        = $clog2(QUO_W);
    localparam int MUL_STEPS     = 5;

    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_MUL  = 3'd2,
        FN_DIV  = 3'd3,
        FN_UNDO = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_SAT      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_UNDO_LD,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       mul_mult;
        logic       mul_acc;
        logic [1:0] mul_idx;
        logic       div_step;
        logic       commit;
        logic       undo_rd;
        logic       undo_ld;
        logic       reject;
        t_status    rej_code;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              opnd_zero;
        logic              hist_empty;
    } t_dstat;

endpackage

@@ hdl/acwu_dpath.sv @@
// acwu_dpath: total register, history memory, sequential multiplier and
// restoring divider. depends on acwu_pkg; driven by acwu_ctrl commands.
module acwu_dpath import acwu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_dstat                   o_stat,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_operand,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_total,
    output t_status                  o_status,
    output logic [CNT_W-1:0]         o_history_count
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } t_satres;

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic t_satres sat_mag(input logic [SATIN_W-1:0] m, input logic neg);
        t_satres r;
        logic    big_pos;
        logic    big_neg;
        big_pos = |m[SATIN_W-1:DATA_W-1];
        big_neg = (|m[SATIN_W-1:DATA_W]) | (m[DATA_W-1] & (|m[DATA_W-2:0]));
        if (neg) begin
            r.sat   = big_neg;
            r.value = big_neg ? DATA_MIN : (~m[DATA_W-1:0] + 1'b1);
        end else begin
            r.sat   = big_pos;
            r.value = big_pos ? DATA_MAX : m[DATA_W-1:0];
        end
        return r;
    endfunction

    logic signed [DATA_W-1:0] r_total;
    logic [FUNC_W-1:0]        r_func;
    logic [DATA_W-1:0]        r_opnd;
    logic [DATA_W-1:0]        r_ma;
    logic [DATA_W-1:0]        r_mb;
    logic                     r_neg;
    logic [DATA_W-1:0]        r_pp;
    logic [1:0]               r_pp_sh;
    logic [PROD_W-1:0]        r_acc;
    logic [DATA_W-1:0]        r_rem;
    logic [QUO_W-1:0]         r_quo;
    logic [DATA_W-1:0]        r_mem [HISTORY_DEPTH];
    logic [DATA_W-1:0]        r_rd_data;
    logic [HIST_AW-1:0]       r_top;
    logic [CNT_W-1:0]         r_count;
    logic                     r_done;
    t_status                  r_status;

    logic [DATA_W:0]      w_sum;
    t_satres              w_sum_res;
    t_satres              w_next;
    logic [HALF_W-1:0]    w_a_sel;
    logic [HALF_W-1:0]    w_b_sel;
    logic [PROD_W-1:0]    w_pp_ext;
    logic [PROD_W-1:0]    w_pp_sft;
    logic [DATA_W:0]      w_rem_sh;
    logic [DATA_W:0]      w_diff;
    logic                 w_ge;
    logic [HIST_AW-1:0]   w_top_p1;
    logic [HIST_AW-1:0]   w_top_m1;
    logic [DATA_W-1:0]    w_mag_total;

    assign w_mag_total = mag(r_total);

    always_comb begin
        if (r_func == FN_SUB) begin
            w_sum = {r_total[DATA_W-1], r_total} - {r_opnd[DATA_W-1], r_opnd};
        end else begin
            w_sum = {r_total[DATA_W-1], r_total} + {r_opnd[DATA_W-1], r_opnd};
        end
        if (w_sum[DATA_W] != w_sum[DATA_W-1]) begin
            w_sum_res.sat   = 1'b1;
            w_sum_res.value = w_sum[DATA_W] ? DATA_MIN : DATA_MAX;
        end else begin
            w_sum_res.sat   = 1'b0;
            w_sum_res.value = w_sum[DATA_W-1:0];
        end
    end

    always_comb begin
        unique case (r_func)
            FN_ADD, FN_SUB: w_next = w_sum_res;
            FN_MUL:         w_next = sat_mag(r_acc[PROD_W-1:FRAC_W], r_neg);
            default:        w_next = sat_mag({{(SATIN_W-QUO_W){1'b0}}, r_quo}, r_neg);
        endcase
    end

    // partial product select and alignment
    assign w_a_sel  = i_cmd.mul_idx[1] ? r_ma[DATA_W-1:HALF_W] : r_ma[HALF_W-1:0];
    assign w_b_sel  = i_cmd.mul_idx[0] ? r_mb[DATA_W-1:HALF_W] : r_mb[HALF_W-1:0];
    assign w_pp_ext = {{(PROD_W-DATA_W){1'b0}}, r_pp};

    always_comb begin
        unique case (r_pp_sh)
            2'd0:    w_pp_sft = w_pp_ext;
            2'd1:    w_pp_sft = w_pp_ext << HALF_W;
            default: w_pp_sft = w_pp_ext << DATA_W;
        endcase
    end

    // one quotient bit per step
    assign w_rem_sh = {r_rem, r_quo[QUO_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_mb};
    assign w_diff   = w_rem_sh - {1'b0, r_mb};

    assign w_top_p1 = (r_top == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : r_top + 1'b1;
    assign w_top_m1 = (r_top == '0) ? HIST_AW'(HISTORY_DEPTH - 1) : r_top - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_top    <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_done <= i_cmd.commit | i_cmd.undo_ld | i_cmd.reject;
            if (i_cmd.commit) begin
                r_total  <= w_next.value;
                r_status <= w_next.sat ? ST_SAT : ST_OK;
                r_top    <= w_top_p1;
                if (r_count != CNT_W'(HISTORY_DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.undo_rd) begin
                r_top   <= w_top_m1;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.undo_ld) begin
                r_total  <= r_rd_data;
                r_status <= ST_OK;
            end
            if (i_cmd.reject) begin
                r_status <= i_cmd.rej_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_opnd <= i_operand;
            r_ma   <= w_mag_total;
            r_mb   <= mag(i_operand);
            r_neg  <= r_total[DATA_W-1] ^ i_operand[DATA_W-1];
            r_acc  <= '0;
            r_rem  <= '0;
            r_quo  <= {w_mag_total, {FRAC_W{1'b0}}};
        end
        if (i_cmd.mul_mult) begin
            r_pp    <= w_a_sel * w_b_sel;
            r_pp_sh <= {i_cmd.mul_idx[1] & i_cmd.mul_idx[0],
                        i_cmd.mul_idx[1] ^ i_cmd.mul_idx[0]};
        end
        if (i_cmd.mul_acc) begin
            r_acc <= r_acc + w_pp_sft;
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_mem[r_top] <= r_total;
        end
        if (i_cmd.undo_rd) begin
            r_rd_data <= r_mem[w_top_m1];
        end
    end

    assign o_stat.func       = r_func;
    assign o_stat.opnd_zero  = (r_opnd == '0);
    assign o_stat.hist_empty = (r_count == '0);

    assign o_done          = r_done;
    assign o_total         = r_total;
    assign o_status        = r_status;
    assign o_history_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HISTORY_DEPTH))
        else $error("history count above depth");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.reject |=> $stable(r_total) && $stable(r_count) && $stable(r_top))
        else $error("rejected word changed state");

    a_undo_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.undo_rd |-> r_count != '0)
        else $error("undo read on empty history");

endmodule

@@ hdl/acwu_ctrl.sv @@
// acwu_ctrl: state machine that sequences each word through the datapath.
// depends on acwu_pkg; issues t_cmd to acwu_dpath and reads t_dstat.
module acwu_ctrl import acwu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_dstat i_stat,
    output t_cmd   o_cmd,
    output logic   o_busy
);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_cnt;
    logic [STEP_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_cnt = '0;
                unique case (i_stat.func)
                    FN_ADD, FN_SUB: n_state = S_COMMIT;
                    FN_MUL:         n_state = S_MUL;
                    FN_DIV: begin
                        if (i_stat.opnd_zero) begin
                            o_cmd.reject   = 1'b1;
                            o_cmd.rej_code = ST_DIV_ZERO;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    FN_UNDO: begin
                        if (i_stat.hist_empty) begin
                            o_cmd.reject   = 1'b1;
                            o_cmd.rej_code = ST_EMPTY;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.undo_rd = 1'b1;
                            n_state       = S_UNDO_LD;
                        end
                    end
                    default: begin
                        o_cmd.reject   = 1'b1;
                        o_cmd.rej_code = ST_OK;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.mul_mult = (r_cnt < STEP_W'(MUL_STEPS - 1));
                o_cmd.mul_idx  = r_cnt[1:0];
                o_cmd.mul_acc  = (r_cnt != '0);
                if (r_cnt == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == STEP_W'(QUO_W - 1)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UNDO_LD: begin
                o_cmd.undo_ld = 1'b1;
                n_state       = S_IDLE;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state == S_DECODE)
        else $error("accepted word not decoded");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT || r_state == S_UNDO_LD) |=> r_state == S_IDLE)
        else $error("no return to idle after result");

    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> r_cnt <= STEP_W'(MUL_STEPS - 1))
        else $error("multiply step count out of range");

endmodule

@@ hdl/accumulator_calculator_with_undo.sv @@
// accumulator_calculator_with_undo: signed Q31.16 running total with undo.
// each word is decoded or rejected; add/sub then commit, multiply runs its steps
// before commit, divide runs the one-bit-per-cycle restoring divider (64 steps)
// before commit, and undo reads history then loads it. busy falls as o_done rises.
// reset (i_rst_n low, synchronous) clears total, history pointer and count.
// results are shown for one cycle on o_done; the receiver cannot stall.
module accumulator_calculator_with_undo import acwu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_operand,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_total,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_history_count
);

    t_cmd    w_cmd;
    t_dstat  w_stat;
    t_status w_status;

    acwu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    acwu_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_func          (i_func),
        .i_operand       (i_operand),
        .o_done          (o_done),
        .o_total         (o_total),
        .o_status        (w_status),
        .o_history_count (o_history_count)
    );

    assign o_status = w_status;

endmodule
